FILE: rtl/core/double_ended_queue_unit_defines.svh
// Assertion macros shared by the deque RTL.
`ifndef DOUBLE_ENDED_QUEUE_UNIT_DEFINES_SVH
`define DOUBLE_ENDED_QUEUE_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define DQU_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define DQU_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/core/dqu_pkg.sv
// Package for the deque: widths, operation and status codes, cell control struct.
`timescale 1ns / 1ps
package dqu_pkg;

	localparam int unsigned DEPTH_DEF   = 16;
	localparam int unsigned WORD_W      = 32;
	localparam int unsigned FUNC_W      = 3;
	localparam int unsigned STATUS_W    = 2;
	localparam int unsigned COUNT_OUT_W = 5;

	typedef logic signed [WORD_W-1:0] word_t;

	typedef enum logic [FUNC_W-1:0] {
		FN_PUSH_BACK  = 3'd0,
		FN_PUSH_FRONT = 3'd1,
		FN_POP_FRONT  = 3'd2,
		FN_POP_BACK   = 3'd3,
		FN_CLEAR      = 3'd4
	} func_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_DONE      = 2'd0,
		ST_UNDERFLOW = 2'd1,
		ST_OVERFLOW  = 2'd2
	} status_t;

	// Per-row control: shift toward the tail with a new word at the head,
	// shift toward the head, or write the new word just past the last entry.
	typedef struct packed {
		logic push_head;
		logic pop_head;
		logic push_tail;
	} dqu_ctl_t;

endpackage

FILE: rtl/core/dqu_cell.sv
// One storage cell of a deque row; takes from either neighbor or the new word.
`timescale 1ns / 1ps
module dqu_cell #(
	parameter int unsigned DEPTH = dqu_pkg::DEPTH_DEF,
	parameter int unsigned INDEX = 0
) (
	input  logic                         clk,
	input  dqu_pkg::dqu_ctl_t            ctl,
	input  logic [$clog2(DEPTH+1)-1:0]   count,
	input  dqu_pkg::word_t               value,
	input  dqu_pkg::word_t               prev_word,
	input  dqu_pkg::word_t               next_word,
	output dqu_pkg::word_t               word
);

	localparam int unsigned CW = $clog2(DEPTH + 1);

	dqu_pkg::word_t word_q;

	always_ff @(posedge clk) begin
		if (ctl.push_head) begin
			word_q <= prev_word;
		end else if (ctl.pop_head) begin
			word_q <= next_word;
		end else if (ctl.push_tail && (count == CW'(INDEX))) begin
			word_q <= value;
		end
	end

	assign word = word_q;

endmodule

FILE: rtl/core/dqu_ctrl.sv
// Operation decode, entry count and status register for the deque.
`timescale 1ns / 1ps
module dqu_ctrl #(
	parameter int unsigned DEPTH = dqu_pkg::DEPTH_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             accept,
	input  logic [dqu_pkg::FUNC_W-1:0]       func,
	output dqu_pkg::dqu_ctl_t                front_ctl,
	output dqu_pkg::dqu_ctl_t                back_ctl,
	output logic [$clog2(DEPTH+1)-1:0]       count,
	output dqu_pkg::status_t                 status
);

	localparam int unsigned CW = $clog2(DEPTH + 1);

	logic [CW-1:0]    count_q;
	logic [CW-1:0]    count_d;
	dqu_pkg::status_t status_q;
	dqu_pkg::status_t status_d;
	logic             full;
	logic             empty;

	assign full  = (count_q == CW'(DEPTH));
	assign empty = (count_q == '0);

	always_comb begin
		front_ctl = '0;
		back_ctl  = '0;
		count_d   = count_q;
		status_d  = status_q;
		if (accept) begin
			status_d = dqu_pkg::ST_DONE;
			unique case (dqu_pkg::func_t'(func))
				dqu_pkg::FN_PUSH_BACK: begin
					if (full) begin
						status_d = dqu_pkg::ST_OVERFLOW;
					end else begin
						front_ctl.push_tail = 1'b1;
						back_ctl.push_head  = 1'b1;
						count_d             = count_q + CW'(1);
					end
				end
				dqu_pkg::FN_PUSH_FRONT: begin
					if (full) begin
						status_d = dqu_pkg::ST_OVERFLOW;
					end else begin
						front_ctl.push_head = 1'b1;
						back_ctl.push_tail  = 1'b1;
						count_d             = count_q + CW'(1);
					end
				end
				dqu_pkg::FN_POP_FRONT: begin
					if (empty) begin
						status_d = dqu_pkg::ST_UNDERFLOW;
					end else begin
						front_ctl.pop_head = 1'b1;
						count_d            = count_q - CW'(1);
					end
				end
				dqu_pkg::FN_POP_BACK: begin
					if (empty) begin
						status_d = dqu_pkg::ST_UNDERFLOW;
					end else begin
						back_ctl.pop_head = 1'b1;
						count_d           = count_q - CW'(1);
					end
				end
				dqu_pkg::FN_CLEAR: begin
					count_d = '0;
				end
				default: begin
					// unused codes: report current state
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			status_q <= dqu_pkg::ST_DONE;
		end else begin
			count_q  <= count_d;
			status_q <= status_d;
		end
	end

	assign count  = count_q;
	assign status = status_q;

endmodule

FILE: rtl/core/double_ended_queue_unit.sv
// Top level of the bounded deque: two rows of cells, one anchored at each end.
// A result is registered: it is valid in the cycle after its item's transfer is accepted.
// Throughput: one item per cycle; a new item is taken when the result slot is free or drains.
// On a transfer each cell holds or updates once, from a neighbor or the input word.
// Reset clears the count, status and result valid; cell contents stay undefined until written.
`timescale 1ns / 1ps
`include "double_ended_queue_unit_defines.svh"
module double_ended_queue_unit #(
	parameter int unsigned DEPTH = dqu_pkg::DEPTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// item channel
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [dqu_pkg::FUNC_W-1:0]          func,
	input  logic signed [dqu_pkg::WORD_W-1:0]   value,
	// result channel
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [dqu_pkg::STATUS_W-1:0]        status,
	output logic signed [dqu_pkg::WORD_W-1:0]   front_value,
	output logic signed [dqu_pkg::WORD_W-1:0]   back_value,
	output logic [dqu_pkg::COUNT_OUT_W-1:0]     entry_count,
	output logic                                is_empty
);

	localparam int unsigned CW = $clog2(DEPTH + 1);

	// The front row keeps the front entry in cell 0 and grows toward higher
	// cells; the back row mirrors it with the back entry in cell 0. Every
	// operation is then a shift or a single-cell write in each row, and both
	// reported words come from fixed cells with no read mux.
	dqu_pkg::word_t    front_row [DEPTH];
	dqu_pkg::word_t    back_row  [DEPTH];
	dqu_pkg::dqu_ctl_t front_ctl;
	dqu_pkg::dqu_ctl_t back_ctl;
	dqu_pkg::status_t  status_w;
	logic [CW-1:0]     count_w;
	logic              accept;
	logic              out_valid_q;

	// A transfer happens when the result slot is empty or is being taken.
	assign in_stall = out_valid_q & out_stall;
	assign accept   = in_valid & ~in_stall;

	dqu_ctrl #(
		.DEPTH(DEPTH)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.func     (func),
		.front_ctl(front_ctl),
		.back_ctl (back_ctl),
		.count    (count_w),
		.status   (status_w)
	);

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		dqu_pkg::word_t fr_prev;
		dqu_pkg::word_t fr_next;
		dqu_pkg::word_t bk_prev;
		dqu_pkg::word_t bk_next;

		// head cell takes the new word on a head push
		if (i == 0) begin : g_head
			assign fr_prev = value;
			assign bk_prev = value;
		end else begin : g_body
			assign fr_prev = front_row[i-1];
			assign bk_prev = back_row[i-1];
		end

		// last cell holds on a head pop; its content is past the count then
		if (i == DEPTH - 1) begin : g_last
			assign fr_next = front_row[i];
			assign bk_next = back_row[i];
		end else begin : g_inner
			assign fr_next = front_row[i+1];
			assign bk_next = back_row[i+1];
		end

		dqu_cell #(
			.DEPTH(DEPTH),
			.INDEX(i)
		) u_front_cell (
			.clk      (clk),
			.ctl      (front_ctl),
			.count    (count_w),
			.value    (value),
			.prev_word(fr_prev),
			.next_word(fr_next),
			.word     (front_row[i])
		);

		dqu_cell #(
			.DEPTH(DEPTH),
			.INDEX(i)
		) u_back_cell (
			.clk      (clk),
			.ctl      (back_ctl),
			.count    (count_w),
			.value    (value),
			.prev_word(bk_prev),
			.next_word(bk_next),
			.word     (back_row[i])
		);
	end

	// Result valid: set by a transfer, dropped once taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// State only moves on a transfer, so the registered state is the result.
	assign out_valid   = out_valid_q;
	assign status      = status_w;
	assign is_empty    = (count_w == '0);
	assign entry_count = dqu_pkg::COUNT_OUT_W'(count_w);
	assign front_value = is_empty ? '0 : front_row[0];
	assign back_value  = is_empty ? '0 : back_row[0];

	`DQU_ASSERT_NOW(a_count_bound, clk, arst_n, 1'b1, count_w <= CW'(DEPTH), "count above depth")
	`DQU_ASSERT_NEXT(a_full_push, clk, arst_n, accept && count_w == CW'(DEPTH) && (func == dqu_pkg::FN_PUSH_BACK || func == dqu_pkg::FN_PUSH_FRONT), status == dqu_pkg::ST_OVERFLOW && $stable(count_w), "push on full not refused")
	`DQU_ASSERT_NEXT(a_empty_pop, clk, arst_n, accept && count_w == '0 && (func == dqu_pkg::FN_POP_FRONT || func == dqu_pkg::FN_POP_BACK), status == dqu_pkg::ST_UNDERFLOW && is_empty, "pop on empty not refused")
	`DQU_ASSERT_NEXT(a_back_push, clk, arst_n, accept && count_w < CW'(DEPTH) && func == dqu_pkg::FN_PUSH_BACK, back_value == $past(value), "back push word not at back")
	`DQU_ASSERT_NEXT(a_front_push, clk, arst_n, accept && count_w < CW'(DEPTH) && func == dqu_pkg::FN_PUSH_FRONT, front_value == $past(value), "front push word not at front")

endmodule
